FILE: hw/rtl/pol_pkg.sv
`default_nettype none

package pol_pkg;

    // Default number of list places.
    localparam int unsigned DepthDefault = 16;

    // Fixed field widths of the words on both channels.
    localparam int unsigned ValueWidth  = 32;
    localparam int unsigned PosWidth    = 5;
    localparam int unsigned StatusWidth = 2;
    localparam int unsigned CountWidth  = 5;

    typedef logic signed [ValueWidth-1:0] word_t;
    typedef logic [StatusWidth-1:0] status_t;

    // Operation codes carried in the func field.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // Status codes reported with every result word.
    localparam status_t ST_DONE    = 2'd0;
    localparam status_t ST_FULL    = 2'd1;
    localparam status_t ST_BAD_POS = 2'd2;

    // What one cell loads at the next clock edge.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_HEAD,
        CELL_LOAD
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        word_t    load_value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pol_req_if.sv
`default_nettype none

interface pol_req_if;
    logic                 valid;
    logic                 ready;
    logic                 func;
    pol_pkg::word_t       value;
    logic [pol_pkg::PosWidth-1:0] position;
    logic                 before_mode;

    modport source (output valid, output func, output value, output position,
                    output before_mode, input ready);
    modport sink (input valid, input func, input value, input position,
                  input before_mode, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pol_rsp_if.sv
`default_nettype none

interface pol_rsp_if;
    logic                              valid;
    logic                              ready;
    pol_pkg::status_t                  status;
    logic [pol_pkg::CountWidth-1:0]    entry_count;
    pol_pkg::word_t                    entry_value;
    logic                              entry_present;
    logic                              last;

    modport source (output valid, output status, output entry_count,
                    output entry_value, output entry_present, output last,
                    input ready);
    modport sink (input valid, input status, input entry_count,
                  input entry_value, input entry_present, input last,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pol_cell.sv
`default_nettype none

// One place of the list. It keeps its word, or takes the word of a
// neighbor, of the head cell, or a new word from the request.
module pol_cell (
    input  wire                 clk,
    input  pol_pkg::cell_ctrl_t ctrl,
    input  pol_pkg::word_t      left_value,
    input  pol_pkg::word_t      right_value,
    input  pol_pkg::word_t      head_value,
    output pol_pkg::word_t      value
);

    pol_pkg::word_t value_reg;
    pol_pkg::word_t value_next;

    always_comb
    begin
        unique case (ctrl.op)
            pol_pkg::CELL_HOLD:  value_next = value_reg;
            pol_pkg::CELL_LEFT:  value_next = left_value;
            pol_pkg::CELL_RIGHT: value_next = right_value;
            pol_pkg::CELL_HEAD:  value_next = head_value;
            pol_pkg::CELL_LOAD:  value_next = ctrl.load_value;
            default:             value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/positional_ordered_list_core.sv
// Positional ordered list. The core keeps up to DEPTH signed 32-bit words
// in a row of cells, cell 0 being the head. A request word either inserts
// a value next to an anchor entry (before it when before_mode is set, the
// anchor then being position-1, otherwise after the entry at position; the
// anchor is clamped to the current contents and an empty list takes the
// value at the head) or deletes the entry at position. An insert into a
// full list reports status 1 and a delete at or beyond the entry count
// reports status 2; neither changes the list. After every request the core
// lists the whole contents from head to tail as a run of response words,
// each carrying the status and the new entry count, the final one marked by
// last; an empty list gives a single word with entry_present low and a zero
// value. Timing: the request is applied to all cells in the cycle it is
// accepted, then one response word is produced per cycle while the response
// side does not stall, by rotating the occupied cells one place toward the
// head. The response register lets the next request be accepted while the
// final word of a run still waits to be taken. Words placed in the cells
// are not cleared at reset; only places below the count are ever shown.
`default_nettype none

module positional_ordered_list_core #(
    parameter int unsigned DEPTH = pol_pkg::DepthDefault
) (
    input  wire       clk,
    input  wire       rst_n,
    pol_req_if.sink   req,
    pol_rsp_if.source rsp
);

    // Count register width, and a common width for position compares.
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned WW = (CW > pol_pkg::PosWidth) ? CW : pol_pkg::PosWidth;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                state_reg,        state_next;
    logic [CW-1:0]         count_reg,        count_next;
    logic [CW-1:0]         remain_reg,       remain_next;
    pol_pkg::status_t      status_reg,       status_next;
    logic                  out_valid_reg,    out_valid_next;
    pol_pkg::status_t      out_status_reg,   out_status_next;
    logic [pol_pkg::CountWidth-1:0] out_count_reg, out_count_next;
    pol_pkg::word_t        out_value_reg,    out_value_next;
    logic                  out_present_reg,  out_present_next;
    logic                  out_last_reg,     out_last_next;

    pol_pkg::word_t        cell_value [DEPTH];
    pol_pkg::cell_ctrl_t   cell_ctrl  [DEPTH];

    logic                  req_fire;
    logic                  emit_fire;
    logic                  rotate;
    logic                  insert_ok;
    logic                  delete_ok;
    logic [WW-1:0]         count_ext;
    logic [WW-1:0]         pos_ext;
    logic [WW-1:0]         anchor_raw;
    logic [WW-1:0]         anchor;
    logic [WW-1:0]         slot;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    // While listing, a new response word is loaded whenever the register is free or drained.
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || rsp.ready);
    assign rotate    = emit_fire && (count_reg != '0);

    assign count_ext = WW'(count_reg);
    assign pos_ext   = WW'(req.position);

    assign insert_ok = (req.func == pol_pkg::FUNC_INSERT) && (count_reg < CW'(DEPTH));
    assign delete_ok = (req.func == pol_pkg::FUNC_DELETE) && (pos_ext < count_ext);

    // Insert slot. The anchor is clamped to the last entry; an empty list
    // always takes the new word at the head.
    always_comb
    begin
        if (req.before_mode)
        begin
            anchor_raw = (pos_ext == '0) ? '0 : pos_ext - WW'(1);
        end
        else
        begin
            anchor_raw = pos_ext;
        end
        if (count_ext == '0)
        begin
            anchor = '0;
        end
        else if (anchor_raw > count_ext - WW'(1))
        begin
            anchor = count_ext - WW'(1);
        end
        else
        begin
            anchor = anchor_raw;
        end
        if (count_ext == '0 || req.before_mode)
        begin
            slot = anchor;
        end
        else
        begin
            slot = anchor + WW'(1);
        end
    end

    // Per-cell control. On an insert, cells from the slot up to the old
    // count shift one place toward the tail and the slot takes the value.
    // On a delete, cells from the position on take their right neighbor.
    // While listing, occupied cells rotate toward the head and the tail
    // cell takes the head word, so the list is whole again after the run.
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        pol_pkg::word_t left_value;
        pol_pkg::word_t right_value;

        always_comb
        begin
            cell_ctrl[k].load_value = req.value;
            cell_ctrl[k].op         = pol_pkg::CELL_HOLD;
            if (req_fire && insert_ok)
            begin
                if (WW'(k) == slot)
                begin
                    cell_ctrl[k].op = pol_pkg::CELL_LOAD;
                end
                else if (WW'(k) > slot && WW'(k) <= count_ext)
                begin
                    cell_ctrl[k].op = pol_pkg::CELL_LEFT;
                end
            end
            else if (req_fire && delete_ok)
            begin
                if (WW'(k) >= pos_ext && WW'(k) + WW'(1) < count_ext)
                begin
                    cell_ctrl[k].op = pol_pkg::CELL_RIGHT;
                end
            end
            else if (rotate)
            begin
                if (WW'(k) + WW'(1) == count_ext)
                begin
                    cell_ctrl[k].op = pol_pkg::CELL_HEAD;
                end
                else if (WW'(k) + WW'(1) < count_ext)
                begin
                    cell_ctrl[k].op = pol_pkg::CELL_RIGHT;
                end
            end
        end

        if (k == 0)
        begin : g_head
            assign left_value = req.value;
        end
        else
        begin : g_body
            assign left_value = cell_value[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_tail
            assign right_value = cell_value[k];
        end
        else
        begin : g_inner
            assign right_value = cell_value[k+1];
        end

        pol_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl[k]),
            .left_value  (left_value),
            .right_value (right_value),
            .head_value  (cell_value[0]),
            .value       (cell_value[k])
        );
    end

    // Sequencing of a request and its response run.
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        remain_next      = remain_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        out_value_next   = out_value_reg;
        out_present_next = out_present_reg;
        out_last_next    = out_last_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (insert_ok)
                    begin
                        count_next  = count_reg + CW'(1);
                        status_next = pol_pkg::ST_DONE;
                    end
                    else if (delete_ok)
                    begin
                        count_next  = count_reg - CW'(1);
                        status_next = pol_pkg::ST_DONE;
                    end
                    else if (req.func == pol_pkg::FUNC_INSERT)
                    begin
                        status_next = pol_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next = pol_pkg::ST_BAD_POS;
                    end
                    remain_next = count_next;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = status_reg;
                    out_count_next   = pol_pkg::CountWidth'(count_reg);
                    out_present_next = (count_reg != '0);
                    out_value_next   = (count_reg != '0) ? cell_value[0] : '0;
                    out_last_next    = (remain_reg <= CW'(1));
                    if (remain_reg <= CW'(1))
                    begin
                        remain_next = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        remain_next = remain_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            status_reg    <= pol_pkg::ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Response payload needs no reset; it is qualified by the valid bit.
    always_ff @(posedge clk)
    begin
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
        out_value_reg   <= out_value_next;
        out_present_reg <= out_present_next;
        out_last_reg    <= out_last_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.entry_count   = out_count_reg;
    assign rsp.entry_value   = out_value_reg;
    assign rsp.entry_present = out_present_reg;
    assign rsp.last          = out_last_reg;

    // The list never holds more entries than there are cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds the number of cells");

    // An accepted request always starts a response run.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == ST_EMIT))
        else $error("accepted request did not start a response run");

    // A word without an entry only stands for an empty list, alone in its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_present_reg) |-> (out_last_reg && out_count_reg == '0))
        else $error("empty-list word is not a lone final word");

    // While a run is in progress, words are still owed unless the list is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (remain_reg != '0 || count_reg == '0))
        else $error("response run lost track of remaining words");

endmodule

`default_nettype wire
